// ===== rtl/complementary_attitude_filter_core_assert.svh =====
// assertion macros for the complementary attitude filter core
// used by the top level only, expects clk_i and rst_ni in scope
`ifndef COMPLEMENTARY_ATTITUDE_FILTER_CORE_ASSERT_SVH
`define COMPLEMENTARY_ATTITUDE_FILTER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CAF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("caf assertion failed");
`define CAF_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("caf forbidden condition");
`else
`define CAF_ASSERT(lbl, prop)
`define CAF_NEVER(lbl, expr)
`endif
`endif

// ===== rtl/caf_pkg.sv =====
// package for the complementary attitude filter core
// widths, sequencer states, axis remap rows, cordic angle table, saturation
`default_nettype none
package caf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CNT_W        = 5;
  localparam int SQRT_ITERS   = 24;
  localparam int AX_W         = 17;
  localparam int D_W          = 30;
  localparam int SQ_W         = 31;
  localparam int ROOT_W       = 24;
  localparam int RAD_W        = 48;
  localparam int REM_W        = 28;
  localparam int CX_W         = 28;
  localparam int Z_W          = 26;
  localparam int MUL_A_W      = 34;
  localparam int MUL_B_W      = 18;
  localparam int MIX_W        = 52;

  localparam logic [3:0]  ORIENT_LAST   = 4'd8;
  localparam logic [15:0] WEIGHT_RESET  = 16'd64225;
  localparam logic        REG_ORIENT    = 1'b0;
  localparam logic        REG_BLEND     = 1'b1;

  // axis codes, the m suffix marks a negated sensor axis
  localparam logic [2:0] AXIS_X  = 3'd0;
  localparam logic [2:0] AXIS_XM = 3'd1;
  localparam logic [2:0] AXIS_Y  = 3'd2;
  localparam logic [2:0] AXIS_YM = 3'd3;
  localparam logic [2:0] AXIS_Z  = 3'd4;
  localparam logic [2:0] AXIS_ZM = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GYRO,
    ST_SQUARE,
    ST_PREP,
    ST_SQRT,
    ST_CORDIC,
    ST_BLEND,
    ST_FIN
  } caf_state_e;

  // remap row: body z code in [8:6], body y in [5:3], body x in [2:0]
  function automatic logic [8:0] remap_row(input logic [3:0] orient);
    logic [8:0] r;
    case (orient)
      4'd0:    r = {AXIS_Z,  AXIS_Y,  AXIS_X};
      4'd1:    r = {AXIS_Z,  AXIS_XM, AXIS_YM};
      4'd2:    r = {AXIS_Z,  AXIS_XM, AXIS_Y};
      4'd3:    r = {AXIS_Z,  AXIS_YM, AXIS_XM};
      4'd4:    r = {AXIS_Z,  AXIS_X,  AXIS_YM};
      4'd5:    r = {AXIS_ZM, AXIS_YM, AXIS_X};
      4'd6:    r = {AXIS_ZM, AXIS_XM, AXIS_YM};
      4'd7:    r = {AXIS_ZM, AXIS_Y,  AXIS_XM};
      4'd8:    r = {AXIS_ZM, AXIS_X,  AXIS_Y};
      default: r = {AXIS_Z,  AXIS_Y,  AXIS_X};
    endcase
    return r;
  endfunction

  function automatic logic signed [AX_W-1:0] pick_axis(
    input logic [2:0] code,
    input logic signed [15:0] vx,
    input logic signed [15:0] vy,
    input logic signed [15:0] vz
  );
    logic signed [AX_W-1:0] v;
    case (code[2:1])
      2'd0:    v = AX_W'(vx);
      2'd1:    v = AX_W'(vy);
      2'd2:    v = AX_W'(vz);
      default: v = AX_W'(vx);
    endcase
    return code[0] ? -v : v;
  endfunction

  // atan(2^-i) in 2^-16 degree units
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [CNT_W-1:0] i);
    logic signed [Z_W-1:0] a;
    case (i)
      5'd0:    a = Z_W'(2949120);
      5'd1:    a = Z_W'(1740967);
      5'd2:    a = Z_W'(919879);
      5'd3:    a = Z_W'(466945);
      5'd4:    a = Z_W'(234379);
      5'd5:    a = Z_W'(117304);
      5'd6:    a = Z_W'(58666);
      5'd7:    a = Z_W'(29335);
      5'd8:    a = Z_W'(14668);
      5'd9:    a = Z_W'(7334);
      5'd10:   a = Z_W'(3667);
      5'd11:   a = Z_W'(1833);
      5'd12:   a = Z_W'(917);
      5'd13:   a = Z_W'(458);
      5'd14:   a = Z_W'(229);
      5'd15:   a = Z_W'(115);
      5'd16:   a = Z_W'(57);
      5'd17:   a = Z_W'(29);
      5'd18:   a = Z_W'(14);
      5'd19:   a = Z_W'(7);
      5'd20:   a = Z_W'(4);
      5'd21:   a = Z_W'(2);
      5'd22:   a = Z_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/complementary_attitude_filter_core.sv =====
// complementary attitude filter core, top level
// depends on caf_pkg and complementary_attitude_filter_core_assert.svh
`default_nettype none
`include "complementary_attitude_filter_core_assert.svh"

// Attitude filter for one IMU sample per input word. The accel and gyro
// samples are remapped to body axes by the orientation register (0..8; any
// other code makes the sample a no-op that returns the held angles). Roll and
// pitch from gravity come from a 24-step restoring square root followed by a
// 16-step vectoring cordic, and are blended with the gyro-integrated angles
// using blend_weight (Q0.16, gyro side). Heading integrates the gyro only.
// All angles are signed 2^-16 degree, saturating. One signed 34x18 multiplier
// does every product in turn: three gyro steps, three squares and two blend
// products per axis. An item passes through the accepting idle state, the
// gyro products, the squares, per axis a setup step, the root steps, the
// cordic steps and the two blend products, then the hand-over state; a
// no-op item goes from the accepting idle state straight to the hand-over.
// The hand-over stalls while the previous word still waits on
// m_axis_tready. s_axis_tready is high only while the sequencer is idle.
// The result sits in its own register, so the next item may start while
// the previous word waits on m_axis_tready.
// Registers: orientation at byte 0, blend_weight at byte 4.
module complementary_attitude_filter_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, time_step (16 bits each)
  input  wire logic [111:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // roll_out, pitch_out, heading_out (32 bits each)
  output logic [95:0]       m_axis_tdata,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import caf_pkg::*;

  // configuration
  logic [3:0]  orient_q;
  logic [15:0] weight_q;
  logic        cfg_wr;

  // sequencer
  caf_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ax_q, ax_d;

  // angle state and result register
  logic signed [31:0] roll_q, roll_d, pitch_q, pitch_d, head_q, head_d;
  logic [95:0]        out_q, out_d;
  logic               mvalid_q, mvalid_d;

  // per item operands
  logic signed [AX_W-1:0] acc_q [3];
  logic signed [AX_W-1:0] rate_q [3];
  logic [15:0]            dt_q;
  logic signed [D_W-1:0]  d_q [3];
  logic [SQ_W-1:0]        sq_q [3];
  logic                   load;
  logic                   d_we, sq_we;
  logic signed [D_W-1:0]  d_new;
  logic [1:0]             idx;

  // square root and cordic datapath
  logic [RAD_W-1:0]       rad_q, rad_d;
  logic [REM_W-1:0]       rem_q, rem_d, rem_n, trial;
  logic [ROOT_W-1:0]      root_q, root_d;
  logic signed [CX_W-1:0] x_q, x_d, y_q, y_d, dx, dy;
  logic signed [Z_W-1:0]  z_q, z_d;
  logic                   nz_q, nz_d;
  logic [31:0]            ssum;
  logic signed [AX_W-1:0] numer;

  // shared multiplier and blend accumulator
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MIX_W-1:0]   mul_p, mix_q, mix_d, mix_sum, mix_rnd, gyro_rnd;
  logic [16:0]               wcomp;
  logic signed [31:0]        old_sel;
  logic signed [D_W-1:0]     d_sel;
  logic signed [31:0]        blend_res;

  logic [8:0] row;

  assign idx = cnt_q[1:0];
  assign row = remap_row(orient_q);

  // configuration port, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[2])
      REG_ORIENT: prdata = {28'd0, orient_q};
      REG_BLEND:  prdata = {16'd0, weight_q};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= '0;
      weight_q <= WEIGHT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ORIENT: orient_q <= pwdata[3:0];
        REG_BLEND:  weight_q <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign load          = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = out_q;

  // shared multiplier
  assign mul_p = MIX_W'(mul_a) * MIX_W'(mul_b);

  // gravity terms: roll uses n = by over (bz, bx), pitch n = -bx over (by, bz)
  assign ssum  = ax_q ? (32'(sq_q[1]) + 32'(sq_q[2])) : (32'(sq_q[2]) + 32'(sq_q[0]));
  assign numer = ax_q ? -acc_q[0] : acc_q[1];

  assign old_sel  = ax_q ? pitch_q : roll_q;
  assign d_sel    = ax_q ? d_q[1] : d_q[0];
  assign wcomp    = 17'h10000 - {1'b0, weight_q};
  assign gyro_rnd = mul_p + MIX_W'(8);
  assign d_new    = D_W'(gyro_rnd >>> 4);
  assign mix_sum  = mix_q + mul_p;
  assign mix_rnd  = mix_sum + MIX_W'(32768);
  assign blend_res = sat32(40'(mix_rnd >>> 16));

  // one restoring square root step, two radicand bits a cycle
  assign rem_n = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial = REM_W'({root_q, 2'b01});

  // one cordic vectoring step
  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ax_d     = ax_q;
    roll_d   = roll_q;
    pitch_d  = pitch_q;
    head_d   = head_q;
    out_d    = out_q;
    mvalid_d = mvalid_q & ~m_axis_tready;
    rad_d    = rad_q;
    rem_d    = rem_q;
    root_d   = root_q;
    x_d      = x_q;
    y_d      = y_q;
    z_d      = z_q;
    nz_d     = nz_q;
    mix_d    = mix_q;
    d_we     = 1'b0;
    sq_we    = 1'b0;
    mul_a    = '0;
    mul_b    = '0;

    case (state_q)
      ST_IDLE: begin
        if (load) begin
          cnt_d   = '0;
          ax_d    = 1'b0;
          state_d = (orient_q > ORIENT_LAST) ? ST_FIN : ST_GYRO;
        end
      end
      ST_GYRO: begin
        // gyro step: round(rate * dt / 16)
        mul_a = MUL_A_W'(rate_q[idx]);
        mul_b = $signed({2'b00, dt_q});
        d_we  = 1'b1;
        if (cnt_q == CNT_W'(2)) begin
          cnt_d   = '0;
          state_d = ST_SQUARE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SQUARE: begin
        mul_a = MUL_A_W'(acc_q[idx]);
        mul_b = MUL_B_W'(acc_q[idx]);
        sq_we = 1'b1;
        if (cnt_q == CNT_W'(2)) begin
          state_d = ST_PREP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_PREP: begin
        rad_d   = {ssum, 16'd0};
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        rad_d = rad_q << 2;
        if (rem_n >= trial) begin
          rem_d  = rem_n - trial;
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_n;
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        if (cnt_q == CNT_W'(SQRT_ITERS - 1)) begin
          x_d     = CX_W'(root_d);
          y_d     = CX_W'(numer) <<< 8;
          z_d     = '0;
          nz_d    = (numer != '0);
          cnt_d   = '0;
          state_d = ST_CORDIC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_CORDIC: begin
        if (!y_q[CX_W-1]) begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + atan_entry(cnt_q);
        end else begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - atan_entry(cnt_q);
        end
        if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_BLEND;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_BLEND: begin
        if (cnt_q == '0) begin
          // gyro side: w * (old + d)
          mul_a = MUL_A_W'(old_sel) + MUL_A_W'(d_sel);
          mul_b = $signed({2'b00, weight_q});
          mix_d = mul_p;
          cnt_d = cnt_q + 1'b1;
        end else begin
          // accel side: (1 - w) * a, zero numerator gives a zero angle
          mul_a = nz_q ? MUL_A_W'(z_q) : '0;
          mul_b = $signed({1'b0, wcomp});
          if (ax_q) begin
            pitch_d = blend_res;
            head_d  = sat32(40'(head_q) + 40'(d_q[2]));
            state_d = ST_FIN;
          end else begin
            roll_d  = blend_res;
            ax_d    = 1'b1;
            state_d = ST_PREP;
          end
        end
      end
      ST_FIN: begin
        // hand over to the result register once it is free
        if (!mvalid_q || m_axis_tready) begin
          out_d    = {head_q, pitch_q, roll_q};
          mvalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      ax_q     <= 1'b0;
      roll_q   <= '0;
      pitch_q  <= '0;
      head_q   <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ax_q     <= ax_d;
      roll_q   <= roll_d;
      pitch_q  <= pitch_d;
      head_q   <= head_d;
      mvalid_q <= mvalid_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    nz_q   <= nz_d;
    mix_q  <= mix_d;
    if (load) begin
      for (int k = 0; k < 3; k++) begin
        acc_q[k]  <= pick_axis(row[3*k +: 3], s_axis_tdata[15:0],
                               s_axis_tdata[31:16], s_axis_tdata[47:32]);
        rate_q[k] <= pick_axis(row[3*k +: 3], s_axis_tdata[63:48],
                               s_axis_tdata[79:64], s_axis_tdata[95:80]);
      end
      dt_q <= s_axis_tdata[111:96];
    end
    if (d_we) begin
      d_q[idx] <= d_new;
    end
    if (sq_we) begin
      sq_q[idx] <= mul_p[SQ_W-1:0];
    end
  end

  // an accepted word always starts the sequencer
  `CAF_ASSERT(a_load_starts, (s_axis_tvalid && s_axis_tready) |=> (state_q != ST_IDLE))
  // iteration counters stay inside their loops
  `CAF_NEVER(a_cordic_cnt, (state_q == ST_CORDIC) && (cnt_q > CNT_W'(CORDIC_STEPS - 1)))
  `CAF_NEVER(a_sqrt_cnt, (state_q == ST_SQRT) && (cnt_q > CNT_W'(SQRT_ITERS - 1)))
  // a finished item waits while the previous word is still pending
  `CAF_ASSERT(a_fin_holds, (state_q == ST_FIN && m_axis_tvalid && !m_axis_tready) |=> (state_q == ST_FIN))

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for complementary_attitude_filter_core
// drives imu sample words and apb writes, predicts roll, pitch and heading
// depends on caf_pkg and the rtl top level only
`timescale 1ns / 1ps

module tb_top;
  import caf_pkg::*;

  typedef struct packed {
    logic [15:0] time_step;
    logic signed [15:0] rate_z, rate_y, rate_x;
    logic signed [15:0] accel_z, accel_y, accel_x;
  } imu_sample_t;

  typedef struct packed {
    logic signed [31:0] heading, pitch, roll;
  } attitude_t;

  // one row of the directed table; has_fixed marks a typed-in expectation
  typedef struct {
    logic [3:0]  orient;
    logic [15:0] weight;
    imu_sample_t sample;
    bit          has_fixed;
    attitude_t   fixed;
  } directed_row_t;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int ADDR_ORIENT  = 0;
  localparam int ADDR_BLEND   = 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  complementary_attitude_filter_core dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [3:0]  orient_q;
  logic [15:0] weight_q;
  logic signed [31:0] roll_q, pitch_q, heading_q;
  attitude_t   attitude_fifo[$];
  int          errors = 0;
  int          src_idle = 0, snk_idle = 0;
  longint      cycles = 0;

  function automatic longint floor_sh(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint sat_angle(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint axis_of(logic [2:0] code, longint v[3]);
    longint r;
    r = v[code[2:1]];
    return code[0] ? -r : r;
  endfunction

  function automatic longint isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // gravity angle atan2(n, sqrt(p^2+q^2)) by vectoring rotations
  function automatic longint tilt_angle(longint n, longint p, longint q);
    longint x, y, z, dx, dy;
    int k;
    longint tbl[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
    if (n == 0) return 0;
    x = isqrt(longint'(p * p + q * q) << 16);
    y = n * 256;
    z = 0;
    for (k = 0; k < CORDIC_STEPS; k++) begin
      dx = floor_sh(y, k);
      dy = floor_sh(x, k);
      if (y >= 0) begin
        x += dx; y -= dy; z += tbl[k];
      end else begin
        x -= dx; y += dy; z -= tbl[k];
      end
    end
    return z;
  endfunction

  function automatic longint mix_angle(longint old, longint d, longint a);
    longint w;
    w = longint'(weight_q);
    return sat_angle(floor_sh(w * (old + d) + (65536 - w) * a + 32768, 16));
  endfunction

  function automatic attitude_t update_attitude(imu_sample_t s);
    longint acc[3], rate[3], b[3], g[3];
    logic [8:0] row;
    attitude_t r;
    int k;
    if (orient_q <= ORIENT_LAST) begin
      row = remap_row(orient_q);
      acc = '{s.accel_x, s.accel_y, s.accel_z};
      rate = '{s.rate_x, s.rate_y, s.rate_z};
      for (k = 0; k < 3; k++) begin
        b[k] = axis_of(row[3*k +: 3], acc);
        g[k] = floor_sh(axis_of(row[3*k +: 3], rate) * longint'(s.time_step) + 8, 4);
      end
      roll_q = 32'(mix_angle(roll_q, g[0], tilt_angle(b[1], b[2], b[0])));
      pitch_q = 32'(mix_angle(pitch_q, g[1], tilt_angle(-b[0], b[1], b[2])));
      heading_q = 32'(sat_angle(longint'(heading_q) + g[2]));
    end
    r.roll = roll_q; r.pitch = pitch_q; r.heading = heading_q;
    return r;
  endfunction

  task automatic reg_write(int addr, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(addr); pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_ORIENT) orient_q = value[3:0];
    else weight_q = value[15:0];
  endtask

  // wait for the pipeline to drain, then give the sequencer time to finish
  task automatic drain();
    while (attitude_fifo.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // tready is stable between edges, so it is looked at on the falling edge
  task automatic send_sample(imu_sample_t s, bit has_fixed, attitude_t fixed);
    attitude_t exp_word;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle) @(negedge clk_i);
    exp_word = update_attitude(s);
    if (has_fixed && exp_word != fixed)
      $display("%0t predictor disagrees with table: exp %h got %h", $time, fixed, exp_word);
    s_axis_tdata <= s;
    s_axis_tvalid <= 1'b1;
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    attitude_fifo.push_back(has_fixed ? fixed : exp_word);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic imu_sample_t rand_sample();
    imu_sample_t s;
    s = 112'({$urandom, $urandom, $urandom, $urandom});
    // mostly realistic short steps, sometimes full range
    if ($urandom_range(3) != 0) s.time_step = 16'($urandom_range(2000));
    return s;
  endfunction

  // receiver: random stalls, checks words against the oldest expectation
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk_i) begin
    attitude_t got, want;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (attitude_fifo.size() == 0) begin
        $display("%0t unexpected word %h", $time, got);
        errors++;
      end else begin
        want = attitude_fifo.pop_front();
        if (got.roll != want.roll)
          $display("%0t roll exp %0d got %0d", $time, want.roll, got.roll);
        if (got.pitch != want.pitch)
          $display("%0t pitch exp %0d got %0d", $time, want.pitch, got.pitch);
        if (got.heading != want.heading)
          $display("%0t heading exp %0d got %0d", $time, want.heading, got.heading);
        if (got != want) errors++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  directed_row_t dir_rows[$];

  function automatic directed_row_t mk(logic [3:0] o, logic [15:0] w, imu_sample_t s,
                                       bit hf, attitude_t f);
    directed_row_t r;
    r.orient = o; r.weight = w; r.sample = s; r.has_fixed = hf; r.fixed = f;
    return r;
  endfunction

  initial begin
    imu_sample_t s;
    attitude_t none;
    int phase, n, k;
    none = '0;
    orient_q = 4'd0; weight_q = WEIGHT_RESET;
    roll_q = 0; pitch_q = 0; heading_q = 0;

    // all zero after reset: zero numerator, zero step, angles stay 0
    dir_rows.push_back(mk(0, WEIGHT_RESET, '0, 1, '0));
    // invalid orientation: held angles come back
    dir_rows.push_back(mk(9, WEIGHT_RESET, {16'hffff, {6{16'sh7fff}}}, 1, '0));
    dir_rows.push_back(mk(15, WEIGHT_RESET, {16'hffff, {6{16'sh8000}}}, 1, '0));
    // every orientation code 0..8 with weight k * 8000; accel x and y full scale, z 16384
    for (k = 0; k < 9; k++) begin
      s = {16'd1000, 16'sh7fff, 16'sh8000, 16'sd1200, 16'sd16384, 16'sh8000, 16'sh7fff};
      dir_rows.push_back(mk(4'(k), 16'(k * 8000), s, 0, none));
    end
    // extremes of weight, step and rates to push into saturation
    for (k = 0; k < 6; k++) begin
      s = {16'hffff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000};
      dir_rows.push_back(mk(0, 16'hffff, s, 0, none));
    end
    for (k = 0; k < 6; k++) begin
      s = {16'hffff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff};
      dir_rows.push_back(mk(3, 16'hffff, s, 0, none));
    end
    dir_rows.push_back(mk(7, 16'd0, {16'd0, {3{16'sd5}}, 16'sd0, 16'sd0, 16'sd300}, 0, none));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    src_idle = 19; snk_idle = 84;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].orient != orient_q || dir_rows[i].weight != weight_q) begin
        drain();
        reg_write(ADDR_ORIENT, 32'(dir_rows[i].orient));
        reg_write(ADDR_BLEND, 32'(dir_rows[i].weight));
      end
      send_sample(dir_rows[i].sample, dir_rows[i].has_fixed, dir_rows[i].fixed);
    end

    // random phases: idle pattern changes every third of the run
    for (phase = 0; phase < 30; phase++) begin
      if (phase == 10) begin src_idle = 84; snk_idle = 19; end
      if (phase == 20) begin src_idle = 0; snk_idle = 0; end
      drain();
      // mostly valid rows, sometimes an invalid code, weight extremes too
      k = $urandom_range(99);
      reg_write(ADDR_ORIENT, k < 85 ? $urandom_range(8) : $urandom_range(15, 9));
      k = $urandom_range(9);
      reg_write(ADDR_BLEND, k == 0 ? 0 : k == 1 ? 32'hffff : $urandom_range(65535));
      n = $urandom_range(30, 55);
      for (k = 0; k < n; k++) send_sample(rand_sample(), 0, none);
    end

    drain();
    if (errors == 0 && attitude_fifo.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/caf_pkg.sv
rtl/complementary_attitude_filter_core.sv
tb/sv/tb_top.sv
